FILE: sv/drlt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Door relay unlock timer package
// Shared types and constants for the relay timer, its register file and core.
// ----------------------------------------------------------------------------
package drlt_pkg;

   // Countdown width, equal to the pulse length register width.
   localparam int unsigned COUNT_WIDTH = 16;

   // Configuration port geometry.
   localparam int unsigned CSR_ADDR_WIDTH = 4;
   localparam int unsigned CSR_DATA_WIDTH = 32;

   // Register indexes, taken from paddr[3:2].
   typedef enum logic [1:0] {
      REG_RELAY_ENABLED     = 2'd0,
      REG_UNLOCK_LEVEL      = 2'd1,
      REG_PULSE_LENGTH_MS   = 2'd2,
      REG_UNTIL_CLOSED_MODE = 2'd3
   } reg_index_type;

   // Event kinds carried in the request sideband.
   typedef enum logic [1:0] {
      KIND_PULSE = 2'd0,
      KIND_OPEN  = 2'd1,
      KIND_CLOSE = 2'd2,
      KIND_TICK  = 2'd3
   } kind_type;

   // Door phase tracking, one-hot.
   typedef enum logic [2:0] {
      PH_IDLE       = 3'b001,
      PH_WAIT_OPEN  = 3'b010,
      PH_WAIT_CLOSE = 3'b100
   } phase_state_type;

   // Phase as reported in a result.
   typedef enum logic [1:0] {
      PHC_IDLE       = 2'd0,
      PHC_WAIT_OPEN  = 2'd1,
      PHC_WAIT_CLOSE = 2'd2
   } phase_code_type;

   // Release cause reported in a result.
   typedef enum logic [1:0] {
      CAUSE_NONE    = 2'd0,
      CAUSE_TIMEOUT = 2'd1,
      CAUSE_CLOSED  = 2'd2
   } cause_type;

   // Status codes.
   typedef enum logic {
      STATUS_OK      = 1'b0,
      STATUS_REFUSED = 1'b1
   } status_type;

   // Register contents plus the return-to-idle request of a changing write.
   typedef struct packed {
      logic                   relay_enabled;
      logic                   unlock_level;
      logic [COUNT_WIDTH-1:0] pulse_length_ms;
      logic                   until_closed_mode;
      logic                   clear;
   } cfg_type;

   // One result item.
   typedef struct packed {
      logic           relay_line;
      logic           unlocked;
      phase_code_type phase;
      status_type     status;
      cause_type      release_cause;
   } result_type;

endpackage
`default_nettype wire

FILE: sv/drlt_csr.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Door relay unlock timer register file
// APB-style register bank; flags a clear whenever a write changes a value.
// ----------------------------------------------------------------------------
module drlt_csr (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_psel,
   input  wire logic                                 csr_penable,
   input  wire logic                                 csr_pwrite,
   input  wire logic [drlt_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  wire logic [drlt_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic      [drlt_pkg::CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                                      csr_pready,
   output drlt_pkg::cfg_type                         cfg
);
   import drlt_pkg::*;

   logic                   relay_enabled_ff, relay_enabled_in;
   logic                   unlock_level_ff, unlock_level_in;
   logic [COUNT_WIDTH-1:0] pulse_length_ff, pulse_length_in;
   logic                   until_closed_ff, until_closed_in;
   logic                   wr_en;
   logic                   changed;
   reg_index_type          index;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign index      = reg_index_type'(csr_paddr[3:2]);

   // Decode the write and note whether it alters the stored value.
   always_comb begin
      relay_enabled_in = relay_enabled_ff;
      unlock_level_in  = unlock_level_ff;
      pulse_length_in  = pulse_length_ff;
      until_closed_in  = until_closed_ff;
      changed          = 1'b0;
      if (wr_en) begin
         unique case (index)
            REG_RELAY_ENABLED: begin
               relay_enabled_in = csr_pwdata[0];
               changed          = csr_pwdata[0] != relay_enabled_ff;
            end
            REG_UNLOCK_LEVEL: begin
               unlock_level_in = csr_pwdata[0];
               changed         = csr_pwdata[0] != unlock_level_ff;
            end
            REG_PULSE_LENGTH_MS: begin
               pulse_length_in = csr_pwdata[COUNT_WIDTH-1:0];
               changed         = csr_pwdata[COUNT_WIDTH-1:0] != pulse_length_ff;
            end
            REG_UNTIL_CLOSED_MODE: begin
               until_closed_in = csr_pwdata[0];
               changed         = csr_pwdata[0] != until_closed_ff;
            end
            default: begin
               changed = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         relay_enabled_ff <= 1'b0;
         unlock_level_ff  <= 1'b1;
         pulse_length_ff  <= COUNT_WIDTH'(3000);
         until_closed_ff  <= 1'b0;
      end else begin
         relay_enabled_ff <= relay_enabled_in;
         unlock_level_ff  <= unlock_level_in;
         pulse_length_ff  <= pulse_length_in;
         until_closed_ff  <= until_closed_in;
      end
   end

   // Read-back mux.
   always_comb begin
      csr_prdata = '0;
      unique case (index)
         REG_RELAY_ENABLED:     csr_prdata[0] = relay_enabled_ff;
         REG_UNLOCK_LEVEL:      csr_prdata[0] = unlock_level_ff;
         REG_PULSE_LENGTH_MS:   csr_prdata[COUNT_WIDTH-1:0] = pulse_length_ff;
         REG_UNTIL_CLOSED_MODE: csr_prdata[0] = until_closed_ff;
         default:               csr_prdata = '0;
      endcase
   end

   assign cfg.relay_enabled     = relay_enabled_ff;
   assign cfg.unlock_level      = unlock_level_ff;
   assign cfg.pulse_length_ms   = pulse_length_ff;
   assign cfg.until_closed_mode = until_closed_ff;
   assign cfg.clear             = changed;

endmodule
`default_nettype wire

FILE: sv/drlt_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Door relay unlock timer core
// Holds the unlock flag, door phase and countdown, and forms one result per
// event from the state that the event leaves behind.
// ----------------------------------------------------------------------------
module drlt_core (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 advance,
   input  wire drlt_pkg::kind_type   kind,
   input  wire logic                 door_open_now,
   input  wire drlt_pkg::cfg_type    cfg,
   output drlt_pkg::result_type      result
);
   import drlt_pkg::*;

   logic                   active_ff, active_in;
   phase_state_type        phase_ff, phase_in;
   logic [COUNT_WIDTH-1:0] remaining_ff, remaining_in;
   status_type             status;
   cause_type              cause;
   logic                   armed;

   assign armed = cfg.relay_enabled && active_ff;

   // Next state for the event in the input register.
   always_comb begin
      active_in    = active_ff;
      phase_in     = phase_ff;
      remaining_in = remaining_ff;
      status       = STATUS_OK;
      cause        = CAUSE_NONE;
      case (kind)
         KIND_PULSE: begin
            if (!cfg.relay_enabled) begin
               status = STATUS_REFUSED;
            end else begin
               active_in    = 1'b1;
               remaining_in = cfg.pulse_length_ms;
               if (cfg.until_closed_mode) begin
                  phase_in = door_open_now ? PH_WAIT_CLOSE : PH_WAIT_OPEN;
               end else begin
                  phase_in = PH_IDLE;
               end
            end
         end
         KIND_OPEN: begin
            if (armed && cfg.until_closed_mode && phase_ff == PH_WAIT_OPEN) begin
               phase_in = PH_WAIT_CLOSE;
            end
         end
         KIND_CLOSE: begin
            if (armed && cfg.until_closed_mode && phase_ff == PH_WAIT_CLOSE) begin
               active_in    = 1'b0;
               phase_in     = PH_IDLE;
               remaining_in = '0;
               cause        = CAUSE_CLOSED;
            end
         end
         default: begin
            // Millisecond tick: count down, release when one or none is left.
            if (armed) begin
               if (remaining_ff <= COUNT_WIDTH'(1)) begin
                  active_in    = 1'b0;
                  phase_in     = PH_IDLE;
                  remaining_in = '0;
                  cause        = CAUSE_TIMEOUT;
               end else begin
                  remaining_in = remaining_ff - COUNT_WIDTH'(1);
               end
            end
         end
      endcase
   end

   // A changing register write returns the block to idle.
   always_ff @(posedge clock) begin
      if (reset || cfg.clear) begin
         active_ff    <= 1'b0;
         phase_ff     <= PH_IDLE;
         remaining_ff <= '0;
      end else if (advance) begin
         active_ff    <= active_in;
         phase_ff     <= phase_in;
         remaining_ff <= remaining_in;
      end
   end

   // Result fields reflect the state after the event.
   always_comb begin
      result.relay_line    = active_in ? cfg.unlock_level : !cfg.unlock_level;
      result.unlocked      = active_in;
      result.status        = status;
      result.release_cause = cause;
      unique case (phase_in)
         PH_IDLE:       result.phase = PHC_IDLE;
         PH_WAIT_OPEN:  result.phase = PHC_WAIT_OPEN;
         PH_WAIT_CLOSE: result.phase = PHC_WAIT_CLOSE;
         default:       result.phase = PHC_IDLE;
      endcase
   end

endmodule
`default_nettype wire

FILE: sv/door_relay_unlock_timer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Door relay unlock timer
// Retriggerable unlock pulse for a door-lock relay with optional early release
// once the door has been opened and closed again.
// ----------------------------------------------------------------------------
// Channel   Direction  Carries
// req_*     in         event: tuser = kind, tdata = door_open_now
// rsp_*     out        one result per event: line, unlocked, phase, status, cause
// csr_*     in/out     APB-style access to the four configuration registers
//
// An event enters the input register, is evaluated from there and its result
// lands in the output register, from which it is offered. One event is taken
// every cycle while the result channel does not stall. The input register
// empties whenever the output register is free or being drained, so a stalled
// result holds only the events behind it. Reset is synchronous.
// ----------------------------------------------------------------------------
module door_relay_unlock_timer (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // Request channel.
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   input  wire logic [7:0]                           req_tdata,  // [0] door_open_now
   input  wire logic [1:0]                           req_tuser,  // [1:0] kind
   // Result channel.
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // [0] relay_line, [1] unlocked, [3:2] phase, [4] status, [6:5] release_cause
   output logic      [7:0]                           rsp_tdata,
   // Configuration port.
   input  wire logic                                 csr_psel,
   input  wire logic                                 csr_penable,
   input  wire logic                                 csr_pwrite,
   input  wire logic [drlt_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  wire logic [drlt_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic      [drlt_pkg::CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                                      csr_pready
);
   import drlt_pkg::*;

   cfg_type    cfg;
   result_type result;
   logic       in_vld_ff;
   kind_type   kind_ff;
   logic       door_open_ff;
   logic       out_vld_ff;
   result_type out_ff;
   logic       advance;

   drlt_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // The held event moves on when the output register can take its result.
   assign advance    = in_vld_ff && (!out_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || advance;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_tready) begin
         in_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         kind_ff      <= kind_type'(req_tuser);
         door_open_ff <= req_tdata[0];
      end
   end

   drlt_core u_core (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .kind          (kind_ff),
      .door_open_now (door_open_ff),
      .cfg           (cfg),
      .result        (result)
   );

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         out_vld_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {1'b0, out_ff.release_cause, out_ff.status, out_ff.phase,
                        out_ff.unlocked, out_ff.relay_line};

endmodule
`default_nettype wire
